// ----- hdl/swr_pkg.sv -----
// Shared types and constants for the sample-without-replacement block.
`default_nettype none
package swr_pkg;

  localparam int DRAWN_W           = 10;
  localparam int CFG_W             = 11;
  localparam int RAND_W            = 32;
  localparam int TAG_W             = 8;
  localparam int POOL_DEPTH_DEF    = 1024;
  localparam int FRACTION_BITS_DEF = 32;

  localparam logic [CFG_W-1:0] POOL_SIZE_RST = 11'd1024;

  typedef struct packed {
    logic              new_set;
    logic [RAND_W-1:0] random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [DRAWN_W-1:0] drawn_value;
    logic               exhausted;
  } out_item_t;

endpackage
`default_nettype wire

// ----- hdl/swr_pool_ram.sv -----
// Pool memory: one write port, two registered read ports.
`default_nettype none
module swr_pool_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 18
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sample_without_replacement.sv -----
// Top level: draws distinct integers by a partial Fisher-Yates shuffle.
//
// Input transfer (in_valid/in_ready) carries one draw request: new_set
// restarts the pool at pool_size entries, random_fraction is a 0.32 fraction
// whose upper FRACTION_BITS bits scale the live count to a slot index.
// Output transfer (out_valid/out_ready) carries one result per request:
// the drawn value, or zero with exhausted set when no entries are left.
// cfg_valid/cfg_ready write pool_size (always ready); it takes effect at
// the next new_set. Write it only while the block is idle.
// A request is taken, then its slot and last entry are read from the pool memory,
// then the swap is written back while the result is registered for output.
// The next draw depends on this pool memory round trip, so a new request is
// not taken in the read cycle; it is taken in the write-back cycle.
// Each entry carries an epoch tag; a new set just bumps the epoch, so
// untouched slots read as their own index.
// Reset: a clearing pass over all POOL_DEPTH entries zeroes all tags, in_ready low.
// The same pass runs again once every 255 new sets, when the epoch wraps.
// Receiver stall: the result waits in the output register; one more request
// is taken and read, then holds in write-back (in_ready low) until it frees.
`default_nettype none
module sample_without_replacement #(
  parameter int POOL_DEPTH    = swr_pkg::POOL_DEPTH_DEF,
  parameter int FRACTION_BITS = swr_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire swr_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output swr_pkg::out_item_t               out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [swr_pkg::CFG_W-1:0]   cfg_data
);

  localparam int IDX_W   = $clog2(POOL_DEPTH);
  localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
  localparam int TAG_W   = swr_pkg::TAG_W;
  localparam int WORD_W  = TAG_W + IDX_W;
  localparam int PROD_W  = CNT_W + FRACTION_BITS;
  localparam int DRAWN_W = swr_pkg::DRAWN_W;
  localparam int RAND_W  = swr_pkg::RAND_W;
  localparam int CFG_W   = swr_pkg::CFG_W;

  localparam logic [TAG_W-1:0] EPOCH_FIRST = TAG_W'(1);
  localparam logic [IDX_W-1:0] CLR_LAST    = IDX_W'(POOL_DEPTH - 1);

  // configuration
  logic [CFG_W-1:0] pool_size_r, pool_size_nxt;

  // shuffle state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TAG_W-1:0] epoch_r, epoch_nxt;
  logic             clr_active_r, clr_active_nxt;
  logic [IDX_W-1:0] clr_addr_r, clr_addr_nxt;

  // draw pipeline: read stage then write-back stage
  logic             rd_v_r, rd_v_nxt;
  logic             wb_v_r, wb_v_nxt;
  logic             live_r;
  logic [IDX_W-1:0] idx_r, last_r;

  logic               out_valid_r, out_valid_nxt;
  swr_pkg::out_item_t out_r;

  logic                     in_fire, rd_go, wb_go;
  logic [CNT_W-1:0]         size_sat, cnt_sel;
  logic [FRACTION_BITS-1:0] frac;
  logic [PROD_W-1:0]        prod;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata, rdata_a, rdata_b;
  logic [IDX_W-1:0]  picked, last_val;

  assign cfg_ready = 1'b1;

  assign rd_go    = rd_v_r && !clr_active_r;
  assign wb_go    = wb_v_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_active_r && !rd_v_r && (!wb_v_r || wb_go);
  assign in_fire  = in_valid && in_ready;

  // live count for this draw, refilled from pool_size on a new set
  assign size_sat = (32'(pool_size_r) > 32'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH)
                                                         : CNT_W'(pool_size_r);
  assign cnt_sel  = in_data.new_set ? size_sat : count_r;
  assign frac     = in_data.random_fraction[RAND_W-1 -: FRACTION_BITS];
  // slot = floor(count * frac), below count whenever count is nonzero
  assign prod     = PROD_W'(cnt_sel) * PROD_W'(frac);

  // untagged (stale-epoch) entries read as their own index
  assign picked   = (rdata_a[WORD_W-1 -: TAG_W] == epoch_r) ? rdata_a[IDX_W-1:0]
                                                            : idx_r;
  assign last_val = (rdata_b[WORD_W-1 -: TAG_W] == epoch_r) ? rdata_b[IDX_W-1:0]
                                                            : last_r;

  // swap write-back, or tag clear during the clearing pass
  assign ram_we    = clr_active_r || (wb_go && live_r);
  assign ram_waddr = clr_active_r ? clr_addr_r : idx_r;
  assign ram_wdata = clr_active_r ? '0 : {epoch_r, last_val};

  swr_pool_ram #(
    .DEPTH (POOL_DEPTH),
    .WIDTH (WORD_W)
  ) u_pool_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (rd_go),
    .raddr_a (idx_r),
    .raddr_b (last_r),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    pool_size_nxt  = cfg_valid ? cfg_data : pool_size_r;
    count_nxt      = count_r;
    epoch_nxt      = epoch_r;
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;

    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + IDX_W'(1);
      if (clr_addr_r == CLR_LAST) begin
        clr_active_nxt = 1'b0;
      end
    end

    if (in_fire) begin
      count_nxt = (cnt_sel != '0) ? cnt_sel - CNT_W'(1) : cnt_sel;
      if (in_data.new_set) begin
        if (epoch_r == '1) begin
          // epoch wrap: old tags must go before any read
          epoch_nxt      = EPOCH_FIRST;
          clr_active_nxt = 1'b1;
          clr_addr_nxt   = '0;
        end else begin
          epoch_nxt = epoch_r + TAG_W'(1);
        end
      end
    end

    rd_v_nxt = rd_v_r;
    if (in_fire) begin
      rd_v_nxt = 1'b1;
    end else if (rd_go) begin
      rd_v_nxt = 1'b0;
    end

    wb_v_nxt = wb_v_r;
    if (rd_go) begin
      wb_v_nxt = 1'b1;
    end else if (wb_go) begin
      wb_v_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (wb_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r  <= swr_pkg::POOL_SIZE_RST;
      count_r      <= '0;
      epoch_r      <= EPOCH_FIRST;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      rd_v_r       <= 1'b0;
      wb_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pool_size_r  <= pool_size_nxt;
      count_r      <= count_nxt;
      epoch_r      <= epoch_nxt;
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      rd_v_r       <= rd_v_nxt;
      wb_v_r       <= wb_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // draw payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r  <= IDX_W'(prod[PROD_W-1 -: CNT_W]);
      last_r <= IDX_W'(cnt_sel - CNT_W'(1));
      live_r <= (cnt_sel != '0);
    end
    if (wb_go) begin
      out_r.drawn_value <= live_r ? DRAWN_W'(picked) : '0;
      out_r.exhausted   <= !live_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // read and write-back stages never hold a draw at once
  a_stage_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_v_r && wb_v_r))
    else $error("read and write-back stages both occupied");

  // swap write lands at or below the count left after the decrement
  a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (wb_go && live_r) |-> (CNT_W'(idx_r) <= count_r))
    else $error("swap write beyond live region");

  // exhausted result only when the pool is empty
  a_exh_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (wb_go && !live_r) |-> (count_r == '0))
    else $error("exhausted reported with entries left");

  // count never grows without a new set
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_data.new_set) |=> (count_r <= $past(count_r)))
    else $error("remaining count grew without a new set");

endmodule
`default_nettype wire
